/* rtl/penalized_fb_element_kernel_top_assert.svh */
// Assertion macros shared by the kernel RTL.
`ifndef PENALIZED_FB_ELEMENT_KERNEL_TOP_ASSERT_SVH
`define PENALIZED_FB_ELEMENT_KERNEL_TOP_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FBK_ASSERT_IMP(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |-> (b)) else $error(msg);

// Next-cycle implication, disabled during reset.
`define FBK_ASSERT_NEXT(lbl, clk, rst, a, b, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (a) |=> (b)) else $error(msg);

`endif

/* rtl/fbk_pkg.sv */
package fbk_pkg;

  // Fixed field widths
  localparam int DATA_W    = 32;
  localparam int EPS_W     = 31;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 31;

  // Register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SMOOTHING_EPS = 2'd0,
    REG_FB_WEIGHT     = 2'd1
  } cfg_reg_t;

  // Input beat
  typedef struct packed {
    logic signed [DATA_W-1:0] x_value;
    logic signed [DATA_W-1:0] y_value;
  } item_beat_t;

  // Result beat
  typedef struct packed {
    logic signed [DATA_W-1:0] residual_phi;
    logic signed [DATA_W-1:0] deriv_x;
    logic signed [DATA_W-1:0] deriv_y;
  } result_beat_t;

endpackage

/* rtl/fbk_isqrt.sv */
// Pipelined digit-by-digit integer square root, one root bit per stage.
module fbk_isqrt #(
  parameter int SW   = 66,
  parameter int SB_W = 8
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    adv,
  input  logic                    in_valid,
  input  logic [SW-1:0]           rad,
  input  logic [SB_W-1:0]         sb_in,
  output logic                    out_valid,
  output logic [(SW+1)/2-1:0]     root,
  output logic [SB_W-1:0]         sb_out
);

  localparam int RW = (SW + 1) / 2;

  logic [SW-1:0]   rem_q  [RW+1];
  logic [RW-1:0]   root_q [RW+1];
  logic [SB_W-1:0] sb_q   [RW+1];
  logic            v_q    [RW+1];

  assign rem_q[0]  = rad;
  assign root_q[0] = '0;
  assign sb_q[0]   = sb_in;
  assign v_q[0]    = in_valid;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [SW:0] trial;
    logic        take;

    // trial = root * 2^(B+1) + 2^(2B)
    assign trial = ((SW+1)'(root_q[k]) << (B + 1)) | ((SW+1)'(1) << (2 * B));
    assign take  = {1'b0, rem_q[k]} >= trial;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_q[k+1]  <= take ? rem_q[k] - trial[SW-1:0] : rem_q[k];
        root_q[k+1] <= root_q[k] | (take ? (RW'(1) << B) : '0);
        sb_q[k+1]   <= sb_q[k];
      end
    end
  end

  assign out_valid = v_q[RW];
  assign root      = root_q[RW];
  assign sb_out    = sb_q[RW];

endmodule

/* rtl/fbk_div.sv */
// Pipelined restoring divider: two numerators over one divisor, one quotient bit
// per stage.
module fbk_div #(
  parameter int NW   = 52,
  parameter int DW   = 33,
  parameter int QB   = 18,
  parameter int SB_W = 8
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            adv,
  input  logic            in_valid,
  input  logic [NW-1:0]   num_a,
  input  logic [NW-1:0]   num_b,
  input  logic [DW-1:0]   den,
  input  logic [SB_W-1:0] sb_in,
  output logic            out_valid,
  output logic [QB-1:0]   quo_a,
  output logic [QB-1:0]   quo_b,
  output logic [SB_W-1:0] sb_out
);

  logic [NW-1:0]   na_q [QB+1];
  logic [NW-1:0]   nb_q [QB+1];
  logic [DW-1:0]   d_q  [QB+1];
  logic [QB-1:0]   qa_q [QB+1];
  logic [QB-1:0]   qb_q [QB+1];
  logic [SB_W-1:0] sb_q [QB+1];
  logic            v_q  [QB+1];

  assign na_q[0] = num_a;
  assign nb_q[0] = num_b;
  assign d_q[0]  = den;
  assign qa_q[0] = '0;
  assign qb_q[0] = '0;
  assign sb_q[0] = sb_in;
  assign v_q[0]  = in_valid;

  for (genvar k = 0; k < QB; k++) begin : g_stage
    localparam int B = QB - 1 - k;
    logic [NW:0] dsh;
    logic        take_a;
    logic        take_b;

    assign dsh    = (NW+1)'(d_q[k]) << B;
    assign take_a = {1'b0, na_q[k]} >= dsh;
    assign take_b = {1'b0, nb_q[k]} >= dsh;

    always_ff @(posedge clk) begin
      if (rst) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        na_q[k+1] <= take_a ? na_q[k] - dsh[NW-1:0] : na_q[k];
        nb_q[k+1] <= take_b ? nb_q[k] - dsh[NW-1:0] : nb_q[k];
        qa_q[k+1] <= qa_q[k] | (take_a ? (QB'(1) << B) : '0);
        qb_q[k+1] <= qb_q[k] | (take_b ? (QB'(1) << B) : '0);
        d_q[k+1]  <= d_q[k];
        sb_q[k+1] <= sb_q[k];
      end
    end
  end

  assign out_valid = v_q[QB];
  assign quo_a     = qa_q[QB];
  assign quo_b     = qb_q[QB];
  assign sb_out    = sb_q[QB];

endmodule

/* rtl/penalized_fb_element_kernel_top.sv */
// The root unit works on RW = max(32,31) + 1 = 33 root bits.
// Throughput: one beat per cycle unless a result stalls; the root unit and the divider
// each retire one bit per stage, so the pipeline depth follows the root width and FRAC_BITS.
// A stalled result freezes the whole pipeline; nothing is dropped.
// Reset (rst, synchronous, active high) clears all valid bits and sets eps to 1 and
// the weight to 1.0.
`include "penalized_fb_element_kernel_top_assert.svh"
module penalized_fb_element_kernel_top #(
  parameter int FRAC_BITS = 16
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                item_valid,
  output logic                                item_ready,
  input  fbk_pkg::item_beat_t                 item,
  output logic                                result_valid,
  input  logic                                result_ready,
  output fbk_pkg::result_beat_t               result,
  input  logic                                cfg_write,
  input  logic [fbk_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [fbk_pkg::CFG_DATA_W-1:0]      cfg_data
);

  localparam int W    = fbk_pkg::DATA_W;
  localparam int EW   = fbk_pkg::EPS_W;
  localparam int F    = FRAC_BITS;
  localparam int LW   = F + 1;
  localparam int SW   = ((W > EW) ? W : EW) * 2 + 2;
  localparam int RW   = (SW + 1) / 2;
  localparam int PXW  = W + LW + 1;          // pen * x products
  localparam int DDW  = RW + 3;              // r - x - y
  localparam int T1W  = DDW + LW + 1;
  localparam int T2W  = 2 * W + LW + 1;
  localparam int NW   = RW + 1 + LW;
  localparam int QB   = F + 2;
  localparam int PW   = ((T1W + F > T2W) ? T1W + F : T2W) + 1;
  localparam int PDW  = PXW + 3;
  localparam int SATW = (PW > PDW) ? PW : PDW;
  localparam int SB1  = 4 * W + 2 * LW + 2 * PXW + 1;
  localparam int SB2  = T1W + T2W + 2 * PXW + 1 + LW + 1;
  localparam logic [LW-1:0] ONE = LW'(1) << F;

  logic adv;

  // Configuration registers
  logic [EW-1:0] eps_reg;
  logic [LW-1:0] weight_reg;
  logic [LW-1:0] lam_c;
  logic [LW-1:0] pen_c;

  always_ff @(posedge clk) begin
    if (rst) begin
      eps_reg    <= EW'(1);
      weight_reg <= ONE;
    end else if (cfg_write) begin
      case (fbk_pkg::cfg_reg_t'(cfg_index))
        fbk_pkg::REG_SMOOTHING_EPS: eps_reg    <= cfg_data[EW-1:0];
        fbk_pkg::REG_FB_WEIGHT:     weight_reg <= cfg_data[LW-1:0];
        default: ;
      endcase
    end
  end

  assign lam_c = (weight_reg > ONE) ? ONE : weight_reg;
  assign pen_c = ONE - lam_c;

  // Stall control: whole pipeline moves when the output slot is free
  assign adv        = !result_valid || result_ready;
  assign item_ready = adv;

  // Stage A: input capture
  logic                a_v;
  logic signed [W-1:0] a_x, a_y;
  logic [LW-1:0]       a_lam, a_pen;
  logic [EW-1:0]       a_eps;

  always_ff @(posedge clk) begin
    if (rst) begin
      a_v <= 1'b0;
    end else if (adv) begin
      a_v <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_x   <= item.x_value;
      a_y   <= item.y_value;
      a_lam <= lam_c;
      a_pen <= pen_c;
      a_eps <= eps_reg;
    end
  end

  // Stage B: squares and the penalty products
  logic signed [2*W-1:0] xx_c, yy_c, xmy_c;
  logic [2*EW-1:0]       ee_c;
  logic signed [W-1:0]   my_c;
  logic signed [PXW-1:0] peny_c, penx_c;
  logic                  b_v;
  logic [SW-1:0]         b_sq;
  logic signed [W-1:0]   b_x, b_y;
  logic [LW-1:0]         b_lam, b_pen;
  logic signed [2*W-1:0] b_xmy;
  logic signed [PXW-1:0] b_peny, b_penx;
  logic                  b_ypos;

  assign my_c   = (a_y > 0) ? a_y : '0;
  assign xx_c   = a_x * a_x;
  assign yy_c   = a_y * a_y;
  assign ee_c   = a_eps * a_eps;
  assign xmy_c  = a_x * my_c;
  assign peny_c = PXW'(a_y) * $signed(PXW'(a_pen));
  assign penx_c = PXW'(a_x) * $signed(PXW'(a_pen));

  always_ff @(posedge clk) begin
    if (rst) begin
      b_v <= 1'b0;
    end else if (adv) begin
      b_v <= a_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_sq   <= SW'($unsigned(xx_c)) + SW'($unsigned(yy_c)) + SW'(ee_c);
      b_x    <= a_x;
      b_y    <= a_y;
      b_lam  <= a_lam;
      b_pen  <= a_pen;
      b_xmy  <= xmy_c;
      b_peny <= peny_c;
      b_penx <= penx_c;
      b_ypos <= a_y > 0;
    end
  end

  // Root stages
  logic                  c_v;
  logic [RW-1:0]         c_r;
  logic [SB1-1:0]        c_sb;
  logic signed [W-1:0]   c_x, c_y;
  logic [LW-1:0]         c_lam, c_pen;
  logic signed [2*W-1:0] c_xmy;
  logic signed [PXW-1:0] c_peny, c_penx;
  logic                  c_ypos;

  fbk_isqrt #(.SW(SW), .SB_W(SB1)) u_isqrt (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (b_v),
    .rad      (b_sq),
    .sb_in    ({b_x, b_y, b_lam, b_pen, b_xmy, b_peny, b_penx, b_ypos}),
    .out_valid(c_v),
    .root     (c_r),
    .sb_out   (c_sb)
  );

  assign {c_x, c_y, c_lam, c_pen, c_xmy, c_peny, c_penx, c_ypos} = c_sb;

  // Stage D: residual products and divider numerators
  logic signed [DDW-1:0] dd_c;
  logic signed [RW+1:0]  rx_c, ry_c;
  logic                  d_v;
  logic signed [T1W-1:0] d_t1;
  logic signed [T2W-1:0] d_t2;
  logic [NW-1:0]         d_nx, d_ny;
  logic [RW-1:0]         d_r;
  logic signed [PXW-1:0] d_peny, d_penx;
  logic                  d_ypos;
  logic [LW-1:0]         d_lam;

  assign dd_c = $signed(DDW'(c_r)) - DDW'(c_x) - DDW'(c_y);
  assign rx_c = $signed((RW+2)'(c_r)) - (RW+2)'(c_x);
  assign ry_c = $signed((RW+2)'(c_r)) - (RW+2)'(c_y);

  always_ff @(posedge clk) begin
    if (rst) begin
      d_v <= 1'b0;
    end else if (adv) begin
      d_v <= c_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_t1   <= T1W'(dd_c) * $signed(T1W'(c_lam));
      d_t2   <= T2W'(c_xmy) * $signed(T2W'(c_pen));
      d_nx   <= NW'(c_lam) * NW'(rx_c[RW:0]);
      d_ny   <= NW'(c_lam) * NW'(ry_c[RW:0]);
      d_r    <= c_r;
      d_peny <= c_peny;
      d_penx <= c_penx;
      d_ypos <= c_ypos;
      d_lam  <= c_lam;
    end
  end

  // Divider stages
  logic                  e_v;
  logic [QB-1:0]         e_qx, e_qy;
  logic [SB2-1:0]        e_sb;
  logic signed [T1W-1:0] e_t1;
  logic signed [T2W-1:0] e_t2;
  logic signed [PXW-1:0] e_peny, e_penx;
  logic                  e_ypos;
  logic [LW-1:0]         e_lam;
  logic                  e_rzero;

  fbk_div #(.NW(NW), .DW(RW), .QB(QB), .SB_W(SB2)) u_div (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .in_valid (d_v),
    .num_a    (d_nx),
    .num_b    (d_ny),
    .den      (d_r),
    .sb_in    ({d_t1, d_t2, d_peny, d_penx, d_ypos, d_lam, d_r == '0}),
    .out_valid(e_v),
    .quo_a    (e_qx),
    .quo_b    (e_qy),
    .sb_out   (e_sb)
  );

  assign {e_t1, e_t2, e_peny, e_penx, e_ypos, e_lam, e_rzero} = e_sb;

  // Final combine and saturation
  function automatic logic [W-1:0] sat(input logic signed [SATW-1:0] v);
    logic signed [SATW-1:0] vmax;
    logic signed [SATW-1:0] vmin;
    vmax = SATW'(signed'({1'b0, {(W-1){1'b1}}}));
    vmin = SATW'(signed'({1'b1, {(W-1){1'b0}}}));
    if (v > vmax) return vmax[W-1:0];
    else if (v < vmin) return vmin[W-1:0];
    else return v[W-1:0];
  endfunction

  logic signed [PW-1:0]  phi_num_c, phi_c;
  logic signed [PDW-1:0] bx_c, by_c, px_c, py_c;

  assign phi_num_c = (PW'(e_t1) <<< F) - PW'(e_t2);
  assign phi_c     = phi_num_c >>> (2 * F);
  assign bx_c      = e_rzero ? -$signed(PDW'(e_lam)) : -$signed(PDW'(e_qx));
  assign by_c      = e_rzero ? -$signed(PDW'(e_lam)) : -$signed(PDW'(e_qy));
  assign px_c      = e_ypos ? bx_c - PDW'(e_peny >>> F) : bx_c;
  assign py_c      = e_ypos ? by_c - PDW'(e_penx >>> F) : by_c;

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (adv) begin
      result_valid <= e_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      result.residual_phi <= sat(SATW'(phi_c));
      result.deriv_x      <= sat(SATW'(px_c));
      result.deriv_y      <= sat(SATW'(py_c));
    end
  end

  `FBK_ASSERT_NEXT(a_stall_hold, clk, rst, result_valid && !result_ready, result_valid && $stable(result), "stalled result changed")
  `FBK_ASSERT_NEXT(a_accept_fill, clk, rst, item_valid && item_ready, a_v, "accepted beat not captured")
  `FBK_ASSERT_IMP(a_lam_clamp, clk, rst, 1'b1, lam_c <= ONE, "weight above one")
  `FBK_ASSERT_IMP(a_pen_sum, clk, rst, 1'b1, (lam_c + pen_c) == ONE, "penalty scale mismatch")

endmodule
